[rtl/lorenz_pkg.sv]
// Shared types, constants and control word layout for the Lorenz step generator.
package lorenz_pkg;

    // Default geometry of the coordinate path
    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed register field widths and scaling
    localparam int GAIN_WIDTH  = 23;
    localparam int STEP_WIDTH  = 24;
    localparam int START_WIDTH = 24;
    localparam int GAIN_FRAC   = 16;
    localparam int STEP_FRAC   = 24;

    // Configuration port geometry
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Program counter width of the sequencer
    localparam int PC_W = 4;

    // Register reset values
    localparam logic [GAIN_WIDTH-1:0]  SIGMA_RST = 23'd655360;
    localparam logic [GAIN_WIDTH-1:0]  RHO_RST   = 23'd1835008;
    localparam logic [GAIN_WIDTH-1:0]  BETA_RST  = 23'd174326;
    localparam logic [STEP_WIDTH-1:0]  STEP_RST  = 24'd83886;
    localparam logic [START_WIDTH-1:0] START_RST = 24'd65536;

    // Register map, one 32-bit slot per register
    typedef enum logic [2:0] {
        REG_SIGMA   = 3'd0,
        REG_RHO     = 3'd1,
        REG_BETA    = 3'd2,
        REG_STEP    = 3'd3,
        REG_START_X = 3'd4,
        REG_START_Y = 3'd5,
        REG_START_Z = 3'd6
    } t_reg_idx;

    // Register contents seen by the datapath
    typedef struct packed {
        logic [GAIN_WIDTH-1:0]             sigma;
        logic [GAIN_WIDTH-1:0]             rho;
        logic [GAIN_WIDTH-1:0]             beta;
        logic [STEP_WIDTH-1:0]             dt;
        logic [2:0][START_WIDTH-1:0]       start;
    } t_cfg;

    // Multiplier operand A source
    typedef enum logic [1:0] {
        A_SIGMA,
        A_X,
        A_BETA,
        A_DT
    } t_asel;

    // Multiplier operand B source
    typedef enum logic [2:0] {
        B_YMX,
        B_RMZ,
        B_Y,
        B_Z,
        B_DX,
        B_DY,
        B_DZ
    } t_bsel;

    // Scaling applied to the registered product
    typedef enum logic [1:0] {
        SH_GAIN,
        SH_FRAC,
        SH_STEP
    } t_shift;

    // Operation on the scaled product
    typedef enum logic [2:0] {
        P_NOP,
        P_LOAD_D,
        P_SUB_Y,
        P_LOAD_T,
        P_SUB_T,
        P_ADD_PT,
        P_RELOAD
    } t_post;

    // Coordinate lane addressed by the post operation
    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } t_axis;

    // One microcode word
    typedef struct packed {
        t_asel           asel;
        t_bsel           bsel;
        t_shift          shift;
        t_post           post;
        t_axis           axis;
        logic            jmp_restart;
        logic [PC_W-1:0] target;
        logic            last;
    } t_uword;

    // Sequencer to datapath control
    typedef struct packed {
        logic   start;
        logic   exec;
        logic   emit;
        t_uword word;
    } t_ctrl;

endpackage

[rtl/lorenz_regs.sv]
// Configuration register file behind the APB-style port.
module lorenz_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lorenz_pkg::APB_AW-1:0]  paddr,
    input  logic [lorenz_pkg::APB_DW-1:0]  pwdata,
    output logic [lorenz_pkg::APB_DW-1:0]  prdata,
    output logic                           pready,
    output lorenz_pkg::t_cfg               o_cfg
);
    import lorenz_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    // Decode the word slot
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sigma    <= SIGMA_RST;
            r_cfg.rho      <= RHO_RST;
            r_cfg.beta     <= BETA_RST;
            r_cfg.dt       <= STEP_RST;
            r_cfg.start[0] <= START_RST;
            r_cfg.start[1] <= START_RST;
            r_cfg.start[2] <= START_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SIGMA:   r_cfg.sigma    <= pwdata[GAIN_WIDTH-1:0];
                REG_RHO:     r_cfg.rho      <= pwdata[GAIN_WIDTH-1:0];
                REG_BETA:    r_cfg.beta     <= pwdata[GAIN_WIDTH-1:0];
                REG_STEP:    r_cfg.dt       <= pwdata[STEP_WIDTH-1:0];
                REG_START_X: r_cfg.start[0] <= pwdata[START_WIDTH-1:0];
                REG_START_Y: r_cfg.start[1] <= pwdata[START_WIDTH-1:0];
                REG_START_Z: r_cfg.start[2] <= pwdata[START_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_SIGMA:   prdata = APB_DW'(r_cfg.sigma);
            REG_RHO:     prdata = APB_DW'(r_cfg.rho);
            REG_BETA:    prdata = APB_DW'(r_cfg.beta);
            REG_STEP:    prdata = APB_DW'(r_cfg.dt);
            REG_START_X: prdata = APB_DW'(r_cfg.start[0]);
            REG_START_Y: prdata = APB_DW'(r_cfg.start[1]);
            REG_START_Z: prdata = APB_DW'(r_cfg.start[2]);
            default:     prdata = '0;
        endcase
    end

endmodule

[rtl/lorenz_seq.sv]
// Microcode sequencer: program ROM, step counter, jumps and word handshakes.
module lorenz_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_restart,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lorenz_pkg::t_ctrl o_ctrl
);
    import lorenz_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    // Entry points of the program
    localparam logic [PC_W-1:0] PC_STEP   = 4'd0;
    localparam logic [PC_W-1:0] PC_RELOAD = 4'd8;

    // Euler step: one product per word, scaled and combined one word later
    function automatic t_uword rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            4'd0:    w = '{A_SIGMA, B_YMX, SH_GAIN, P_NOP,    AX_X, 1'b1, PC_RELOAD, 1'b0};
            4'd1:    w = '{A_X,     B_RMZ, SH_GAIN, P_LOAD_D, AX_X, 1'b0, PC_STEP,   1'b0};
            4'd2:    w = '{A_X,     B_Y,   SH_FRAC, P_SUB_Y,  AX_Y, 1'b0, PC_STEP,   1'b0};
            4'd3:    w = '{A_BETA,  B_Z,   SH_FRAC, P_LOAD_T, AX_X, 1'b0, PC_STEP,   1'b0};
            4'd4:    w = '{A_DT,    B_DX,  SH_GAIN, P_SUB_T,  AX_Z, 1'b0, PC_STEP,   1'b0};
            4'd5:    w = '{A_DT,    B_DY,  SH_STEP, P_ADD_PT, AX_X, 1'b0, PC_STEP,   1'b0};
            4'd6:    w = '{A_DT,    B_DZ,  SH_STEP, P_ADD_PT, AX_Y, 1'b0, PC_STEP,   1'b0};
            4'd7:    w = '{A_DT,    B_DZ,  SH_STEP, P_ADD_PT, AX_Z, 1'b0, PC_STEP,   1'b1};
            4'd8:    w = '{A_DT,    B_DZ,  SH_STEP, P_RELOAD, AX_X, 1'b0, PC_STEP,   1'b1};
            default: w = '{A_DT,    B_DZ,  SH_STEP, P_NOP,    AX_X, 1'b0, PC_STEP,   1'b1};
        endcase
        return w;
    endfunction

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_restart, n_restart;
    logic            r_out_valid, n_out_valid;
    t_uword          uw;
    logic            accept;
    logic            emit;

    // Next-state and program flow
    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_restart   = r_restart;
        n_out_valid = r_out_valid && i_out_stall;
        uw          = rom(r_pc);
        accept      = 1'b0;
        emit        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    accept    = 1'b1;
                    n_state   = S_RUN;
                    n_pc      = PC_STEP;
                    n_restart = i_restart;
                end
            end
            S_RUN: begin
                if (uw.jmp_restart && r_restart) begin
                    n_pc = uw.target;
                end else if (uw.last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            S_DRAIN: begin
                // move the point into the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    emit        = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= PC_STEP;
            r_restart   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_restart   <= n_restart;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_ctrl.start = accept;
        o_ctrl.exec  = (r_state == S_RUN);
        o_ctrl.emit  = emit;
        o_ctrl.word  = uw;
    end

endmodule

[rtl/lorenz_dp.sv]
// Datapath: shared multiplier, scaling and clamping, point and derivative registers.
module lorenz_dp #(
    parameter int CW = lorenz_pkg::COORD_WIDTH_DEF,
    parameter int FB = lorenz_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lorenz_pkg::t_ctrl    i_ctrl,
    input  lorenz_pkg::t_cfg     i_cfg,
    output logic signed [CW-1:0] o_coord_x,
    output logic signed [CW-1:0] o_coord_y,
    output logic signed [CW-1:0] o_coord_z,
    output logic                 o_clipped
);
    import lorenz_pkg::*;

    // rho realigned from 16 fractional bits to FB
    localparam int RW    = GAIN_WIDTH - GAIN_FRAC + FB;
    localparam int RSH_L = (FB >= GAIN_FRAC) ? FB - GAIN_FRAC : 0;
    localparam int RSH_R = (FB >= GAIN_FRAC) ? 0 : GAIN_FRAC - FB;
    localparam int RWW   = GAIN_WIDTH + GAIN_FRAC;
    localparam int RZW   = ((RW + 1 > CW) ? RW + 1 : CW) + 1;
    // Derivative width bounds, capped by the internal clamp
    localparam int DXB   = GAIN_WIDTH + 1 + CW + 1 - GAIN_FRAC;
    localparam int DYM   = CW + RZW - FB;
    localparam int DYB   = ((DYM > CW) ? DYM : CW) + 1;
    localparam int XYB   = 2 * CW - FB;
    localparam int BZB   = GAIN_WIDTH + 1 + CW - GAIN_FRAC;
    localparam int DZB   = ((XYB > BZB) ? XYB : BZB) + 1;
    localparam int DM0   = (DXB > DYB) ? DXB : DYB;
    localparam int DMAX  = (DM0 > DZB) ? DM0 : DZB;
    localparam int DW    = (DMAX > 63) ? 63 : DMAX;
    // Multiplier geometry
    localparam int AW    = (CW > STEP_WIDTH + 1) ? CW : STEP_WIDTH + 1;
    localparam int BW0   = (DW > RZW) ? DW : RZW;
    localparam int BW    = (BW0 > CW + 1) ? BW0 : CW + 1;
    localparam int PW    = AW + BW;
    localparam int EW    = (PW > 64) ? PW : 64;
    // Start point alignment
    localparam int SA0   = START_WIDTH + RSH_L;
    localparam int ALW   = ((SA0 > CW) ? SA0 : CW) + 1;

    localparam logic signed [EW:0]   LIMP   = (EW+1)'(1) <<< 61;
    localparam logic signed [EW:0]   LIMN   = -LIMP;
    localparam logic signed [CW-1:0] PT_ONE = CW'(64'd1 << FB);

    // Clamp to the internal range of plus or minus 2^61
    function automatic logic signed [EW:0] lim(input logic signed [EW:0] v);
        if (v > LIMP) begin
            return LIMP;
        end else if (v < LIMN) begin
            return LIMN;
        end
        return v;
    endfunction

    // Saturate to the coordinate range, flag in the top bit
    function automatic logic [CW:0] sat_cw(input logic signed [EW:0] v);
        logic same;
        same = (&v[EW:CW-1]) || !(|v[EW:CW-1]);
        if (same) begin
            return {1'b0, v[CW-1:0]};
        end else if (v[EW]) begin
            return {1'b1, 1'b1, {(CW-1){1'b0}}};
        end
        return {1'b1, 1'b0, {(CW-1){1'b1}}};
    endfunction

    t_uword                uw;
    logic signed [CW-1:0]  r_pt [3];
    logic signed [CW-1:0]  n_pt [3];
    logic signed [DW-1:0]  r_d [3];
    logic signed [DW-1:0]  n_d [3];
    logic signed [DW-1:0]  r_t, n_t;
    logic                  r_clip, n_clip;
    logic signed [PW-1:0]  r_prod;
    logic signed [CW-1:0]  r_out [3];
    logic                  r_out_clip;

    logic [RWW-1:0]        rho_wide;
    logic [RW-1:0]         rho_al;
    logic signed [CW:0]    ymx;
    logic signed [RZW-1:0] rmz;
    logic signed [AW-1:0]  op_a;
    logic signed [BW-1:0]  op_b;
    logic signed [EW:0]    prod_x;
    logic signed [EW:0]    sh;
    logic signed [EW:0]    p_cl;
    logic [1:0]            ax_i;
    logic [CW:0]           add_sat;
    logic signed [ALW-1:0] al [3];
    logic [CW:0]           rl_sat [3];

    assign uw = i_ctrl.word;

    // Form operands
    always_comb begin
        rho_wide = RWW'(i_cfg.rho);
        rho_al   = RW'((rho_wide << RSH_L) >> RSH_R);
        ymx      = (CW+1)'(r_pt[1]) - (CW+1)'(r_pt[0]);
        rmz      = $signed(RZW'(rho_al)) - RZW'(r_pt[2]);
        case (uw.asel)
            A_SIGMA: op_a = AW'(i_cfg.sigma);
            A_X:     op_a = AW'(r_pt[0]);
            A_BETA:  op_a = AW'(i_cfg.beta);
            A_DT:    op_a = AW'(i_cfg.dt);
            default: op_a = '0;
        endcase
        case (uw.bsel)
            B_YMX:   op_b = BW'(ymx);
            B_RMZ:   op_b = BW'(rmz);
            B_Y:     op_b = BW'(r_pt[1]);
            B_Z:     op_b = BW'(r_pt[2]);
            B_DX:    op_b = BW'(r_d[0]);
            B_DY:    op_b = BW'(r_d[1]);
            B_DZ:    op_b = BW'(r_d[2]);
            default: op_b = '0;
        endcase
    end

    // Scale the registered product, rounding toward minus infinity, then clamp
    always_comb begin
        prod_x = (EW+1)'(r_prod);
        case (uw.shift)
            SH_GAIN: sh = prod_x >>> GAIN_FRAC;
            SH_FRAC: sh = prod_x >>> FB;
            SH_STEP: sh = prod_x >>> STEP_FRAC;
            default: sh = prod_x;
        endcase
        p_cl = lim(sh);
        case (uw.axis)
            AX_X:    ax_i = 2'd0;
            AX_Y:    ax_i = 2'd1;
            AX_Z:    ax_i = 2'd2;
            default: ax_i = 2'd0;
        endcase
        add_sat = sat_cw(p_cl + (EW+1)'(r_pt[ax_i]));
        for (int i = 0; i < 3; i++) begin
            al[i]     = ALW'($signed(i_cfg.start[i]));
            al[i]     = al[i] <<< RSH_L;
            al[i]     = al[i] >>> RSH_R;
            rl_sat[i] = sat_cw((EW+1)'(al[i]));
        end
    end

    // Apply the post operation of the current word
    always_comb begin
        n_pt   = r_pt;
        n_d    = r_d;
        n_t    = r_t;
        n_clip = r_clip;
        if (i_ctrl.start) begin
            n_clip = 1'b0;
        end
        if (i_ctrl.exec) begin
            case (uw.post)
                P_LOAD_D: n_d[ax_i] = DW'(p_cl);
                P_SUB_Y:  n_d[ax_i] = DW'(lim(p_cl - (EW+1)'(r_pt[1])));
                P_LOAD_T: n_t = DW'(p_cl);
                P_SUB_T:  n_d[ax_i] = DW'(lim((EW+1)'(r_t) - p_cl));
                P_ADD_PT: begin
                    n_pt[ax_i] = add_sat[CW-1:0];
                    n_clip     = r_clip | add_sat[CW];
                end
                P_RELOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        n_pt[i] = rl_sat[i][CW-1:0];
                    end
                    n_clip = rl_sat[0][CW] | rl_sat[1][CW] | rl_sat[2][CW];
                end
                default: ;
            endcase
        end
    end

    // Hold the point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pt[i] <= PT_ONE;
            end
        end else begin
            r_pt <= n_pt;
        end
    end

    // Advance product, scratch and output registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            r_prod <= op_a * op_b;
        end
        r_d    <= n_d;
        r_t    <= n_t;
        r_clip <= n_clip;
        if (i_ctrl.emit) begin
            r_out      <= r_pt;
            r_out_clip <= r_clip;
        end
    end

    assign o_coord_x = r_out[0];
    assign o_coord_y = r_out[1];
    assign o_coord_z = r_out[2];
    assign o_clipped = r_out_clip;

endmodule

[rtl/lorenz_euler_step_generator.sv]
// Top level of the Lorenz attractor Euler step generator.
//
//  channel   direction  handshake                  payload
//  in        to block   i_in_valid / o_in_stall    i_restart
//  out       from block o_out_valid / i_out_stall  o_coord_x/y/z, o_clipped
//  config    to block   psel/penable/pwrite/pready paddr, pwdata -> prdata
//
// An Euler step, from one accepted word to the next: the word is accepted, eight
// program words run through the single shared multiplier, then the output loads.
// A restart word runs word 0, jumps to the reload word and then loads the output.
// Reset loads the default gains, dt and start point, sets the point to 1.0 and
// empties the output register.
// A stalled result holds in the output register while the next word is accepted
// and computed; that result then waits until the output register frees.
module lorenz_euler_step_generator #(
    parameter int COORD_WIDTH = lorenz_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = lorenz_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_restart,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [COORD_WIDTH-1:0]  o_coord_x,
    output logic signed [COORD_WIDTH-1:0]  o_coord_y,
    output logic signed [COORD_WIDTH-1:0]  o_coord_z,
    output logic                           o_clipped,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lorenz_pkg::APB_AW-1:0]  paddr,
    input  logic [lorenz_pkg::APB_DW-1:0]  pwdata,
    output logic [lorenz_pkg::APB_DW-1:0]  prdata,
    output logic                           pready
);
    import lorenz_pkg::*;

    t_cfg  cfg;
    t_ctrl ctrl;

    // Configuration registers
    lorenz_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Microcode sequencer
    lorenz_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_restart   (i_restart),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctrl      (ctrl)
    );

    // Arithmetic datapath
    lorenz_dp #(
        .CW (COORD_WIDTH),
        .FB (FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_cfg     (cfg),
        .o_coord_x (o_coord_x),
        .o_coord_y (o_coord_y),
        .o_coord_z (o_coord_z),
        .o_clipped (o_clipped)
    );

endmodule

[rtl/lorenz_chk.sv]
// Port-level checker for the Lorenz step generator, bound to the top level.
module lorenz_chk #(
    parameter int COORD_WIDTH = lorenz_pkg::COORD_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [COORD_WIDTH-1:0] o_coord_x,
    input logic signed [COORD_WIDTH-1:0] o_coord_y,
    input logic signed [COORD_WIDTH-1:0] o_coord_z,
    input logic                          o_clipped
);
    logic [1:0] r_pend, n_pend;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Count words accepted but not yet delivered
    always_comb begin
        n_pend = r_pend;
        if (in_acc && !out_acc) begin
            n_pend = r_pend + 2'd1;
        end else if (out_acc && !in_acc) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_coord_x) && $stable(o_coord_y)
            && $stable(o_coord_z) && $stable(o_clipped))
        else $error("result changed while stalled");

    // One word at a time enters the sequencer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken again right after an accept");

    // No result without a word behind it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 2'd0)
        else $error("result offered with nothing outstanding");

    // At most one word waits in the output register while the block is open
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> r_pend == 2'd0 || r_pend == 2'd1)
        else $error("input open with two words outstanding");

endmodule

bind lorenz_euler_step_generator lorenz_chk #(
    .COORD_WIDTH (COORD_WIDTH)
) u_lorenz_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_coord_x   (o_coord_x),
    .o_coord_y   (o_coord_y),
    .o_coord_z   (o_coord_z),
    .o_clipped   (o_clipped)
);
